[rtl/core/bmz_pkg.sv]
// Shared widths, codes and pipeline payload types for the bed mesh Z correction block.
package bmz_pkg;

    localparam int POS_W  = 32;
    localparam int VAL_W  = 32;
    localparam int CELL_W = 20;
    localparam int IDX_W  = 6;
    localparam int CIDX_W = 4;
    localparam int PROD_W = VAL_W + CELL_W;
    localparam int FPROD_W = 2 * VAL_W;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [CIDX_W-1:0] REG_X_SHIFT    = 4'd0;
    localparam logic [CIDX_W-1:0] REG_Y_SHIFT    = 4'd1;
    localparam logic [CIDX_W-1:0] REG_CELL_X     = 4'd2;
    localparam logic [CIDX_W-1:0] REG_CELL_Y     = 4'd3;
    localparam logic [CIDX_W-1:0] REG_Z_SHIFT    = 4'd4;
    localparam logic [CIDX_W-1:0] REG_FADE_START = 4'd5;
    localparam logic [CIDX_W-1:0] REG_FADE_END   = 4'd6;
    localparam logic [CIDX_W-1:0] REG_Z_FLOOR    = 4'd7;

    typedef struct packed {
        logic mode;
        logic kill;
        logic fade;
    } t_ctl;

    typedef struct packed {
        t_ctl             ctl;
        logic [VAL_W-1:0] n;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic             xneg;
        logic             xclp;
    } t_loc_tag;

    typedef struct packed {
        logic yneg;
        logic yclp;
    } t_locy_tag;

    typedef struct packed {
        t_ctl              ctl;
        logic [VAL_W-1:0]  n;
        logic [VAL_W-1:0]  m11;
        logic              s1;
        logic [CELL_W-1:0] fy;
    } t_fx_tag;

    typedef struct packed {
        logic             s2;
        logic [VAL_W-1:0] m21;
    } t_fxh_tag;

    typedef struct packed {
        t_ctl             ctl;
        logic [VAL_W-1:0] n;
        logic [VAL_W-1:0] zx1;
        logic             se;
    } t_fy_tag;

    typedef struct packed {
        t_ctl             ctl;
        logic [VAL_W-1:0] corr;
        logic             sc;
    } t_fd_tag;

endpackage

[rtl/core/bmz_ram.sv]
// Generic RAM: one write port, two registered read ports.
module bmz_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

[rtl/core/bmz_div.sv]
// Pipelined restoring unsigned divider, one quotient bit per stage, with sideband tag.
module bmz_div #(
    parameter int DW = 32,
    parameter int VW = 20,
    parameter int QW = 32,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_dvd,
    input  logic [VW-1:0] i_dvs,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [VW-1:0] o_rem,
    output logic [TW-1:0] o_tag
);

    localparam int XW = (DW > VW + QW) ? DW : VW + QW;

    logic          r_vld [QW];
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_quo [QW];
    logic [TW-1:0] r_tag [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int B = QW - 1 - s;
        logic          w_vld_in;
        logic [DW-1:0] w_rem_in;
        logic [QW-1:0] w_quo_in;
        logic [TW-1:0] w_tag_in;
        logic [XW-1:0] w_sub;
        logic          w_ge;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (s == 0) begin : g_first
            assign w_vld_in = i_valid;
            assign w_rem_in = i_dvd;
            assign w_quo_in = '0;
            assign w_tag_in = i_tag;
        end else begin : g_next
            assign w_vld_in = r_vld[s-1];
            assign w_rem_in = r_rem[s-1];
            assign w_quo_in = r_quo[s-1];
            assign w_tag_in = r_tag[s-1];
        end

        assign w_sub = XW'(i_dvs) << B;
        assign w_ge  = XW'(w_rem_in) >= w_sub;

        always_comb begin
            n_quo    = w_quo_in;
            n_quo[B] = w_ge;
            n_rem    = w_ge ? DW'(XW'(w_rem_in) - w_sub) : w_rem_in;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
                r_tag[s] <= w_tag_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_rem   = r_rem[QW-1][VW-1:0];
    assign o_tag   = r_tag[QW-1];

endmodule

[rtl/core/bed_mesh_z_correction.sv]
// Throughput: one beat per cycle while the output accepts; the four 32-stage dividers and the two
// cell locate dividers are fully pipelined. A stalled output freezes the whole pipeline in place.
// Reset: synchronous, active low; clears pipeline valids, grid entry valid bits (grid reads 0)
// and the registers (cell sizes to 1, all others to 0). No clearing pass.
module bed_mesh_z_correction
    import bmz_pkg::*;
#(
    parameter int GRID_POINTS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_mode,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic                    i_suppress,
    input  logic [IDX_W-1:0]        i_entry_index,
    input  logic signed [VAL_W-1:0] i_entry_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_correction,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CIDX_W-1:0]       i_cfg_index,
    input  logic [31:0]             i_cfg_data
);

    localparam int GS = GRID_POINTS * GRID_POINTS;
    localparam int AW = $clog2(GS);
    localparam int QB = $clog2(GRID_POINTS);
    localparam int LW = CELL_W + QB;

    // registers
    logic signed [31:0] r_x_shift, r_y_shift, r_z_shift, r_fade_start, r_fade_end, r_z_floor;
    logic [CELL_W-1:0]  r_cell_x, r_cell_y;
    logic [LW-1:0]      r_lim_x, r_lim_y;
    logic [VAL_W-1:0]   r_fden;
    logic [CELL_W-1:0]  n_cell;

    logic adv;

    assign adv         = !o_out_valid || i_out_ready;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;
    assign n_cell      = (i_cfg_data[CELL_W-1:0] == '0) ? CELL_W'(1) : i_cfg_data[CELL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_shift    <= '0;
            r_y_shift    <= '0;
            r_z_shift    <= '0;
            r_fade_start <= '0;
            r_fade_end   <= '0;
            r_z_floor    <= '0;
            r_cell_x     <= CELL_W'(1);
            r_cell_y     <= CELL_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_X_SHIFT:    r_x_shift    <= i_cfg_data;
                REG_Y_SHIFT:    r_y_shift    <= i_cfg_data;
                REG_CELL_X:     r_cell_x     <= n_cell;
                REG_CELL_Y:     r_cell_y     <= n_cell;
                REG_Z_SHIFT:    r_z_shift    <= i_cfg_data;
                REG_FADE_START: r_fade_start <= i_cfg_data;
                REG_FADE_END:   r_fade_end   <= i_cfg_data;
                REG_Z_FLOOR:    r_z_floor    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // derived constants, settle while idle
    always_ff @(posedge i_clk) begin
        r_lim_x <= LW'(r_cell_x * (GRID_POINTS - 1));
        r_lim_y <= LW'(r_cell_y * (GRID_POINTS - 1));
        r_fden  <= VAL_W'(r_fade_end - r_fade_start);
    end

    // input stage: shifts
    logic               r0_vld;
    logic               r0_mode, r0_sup;
    logic signed [32:0] r0_px, r0_py, r0_z;
    logic [IDX_W-1:0]   r0_idx;
    logic [VAL_W-1:0]   r0_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (adv) begin
            r0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_mode <= i_mode;
            r0_sup  <= i_suppress;
            r0_px   <= 33'(i_pos_x) - 33'(r_x_shift);
            r0_py   <= 33'(i_pos_y) - 33'(r_y_shift);
            r0_z    <= 33'(i_pos_z) + 33'(r_z_shift);
            r0_idx  <= i_entry_index;
            r0_val  <= i_entry_value;
        end
    end

    // edge clamp and fade decisions, then cell locate
    logic               n_xneg, n_xclp, n_yneg, n_yclp;
    logic [31:0]        n_dvd_x, n_dvd_y;
    logic signed [32:0] n_fe, n_fn;
    t_loc_tag           n_ltag, lx_tag;
    t_locy_tag          n_ytag, ly_tag;

    always_comb begin
        n_xneg = r0_px[32];
        n_yneg = r0_py[32];
        n_xclp = !n_xneg && (r0_px[31:0] >= 32'(r_lim_x));
        n_yclp = !n_yneg && (r0_py[31:0] >= 32'(r_lim_y));
        n_dvd_x = (n_xneg || n_xclp) ? '0 : r0_px[31:0];
        n_dvd_y = (n_yneg || n_yclp) ? '0 : r0_py[31:0];
        n_fe = 33'(r_fade_end);
        n_fn = n_fe - r0_z;
        n_ltag.ctl.mode = r0_mode;
        n_ltag.ctl.kill = r0_sup || (r0_z > n_fe);
        n_ltag.ctl.fade = (r0_z > 33'(r_fade_start)) && (r0_z > 33'(r_z_floor));
        n_ltag.n    = n_fn[31:0];
        n_ltag.idx  = r0_idx;
        n_ltag.val  = r0_val;
        n_ltag.xneg = n_xneg;
        n_ltag.xclp = n_xclp;
        n_ytag.yneg = n_yneg;
        n_ytag.yclp = n_yclp;
    end

    logic              lx_vld;
    logic [QB-1:0]     lx_quo, ly_quo;
    logic [CELL_W-1:0] lx_rem, ly_rem;

    bmz_div #(.DW(32), .VW(CELL_W), .QW(QB), .TW($bits(t_loc_tag))) u_loc_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r0_vld),
        .i_dvd   (n_dvd_x),
        .i_dvs   (r_cell_x),
        .i_tag   (n_ltag),
        .o_valid (lx_vld),
        .o_quo   (lx_quo),
        .o_rem   (lx_rem),
        .o_tag   (lx_tag)
    );

    bmz_div #(.DW(32), .VW(CELL_W), .QW(QB), .TW($bits(t_locy_tag))) u_loc_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r0_vld),
        .i_dvd   (n_dvd_y),
        .i_dvs   (r_cell_y),
        .i_tag   (n_ytag),
        .o_valid (),
        .o_quo   (ly_quo),
        .o_rem   (ly_rem),
        .o_tag   (ly_tag)
    );

    // grid access; writes happen here so order with queries is kept
    logic [QB-1:0]     n_ix, n_iy;
    logic [CELL_W-1:0] n_fx, n_fy;
    logic [AW-1:0]     n_base, n_a12, n_a21, n_a22, n_waddr;
    logic              n_we;
    logic [GS-1:0]     r_gvld;
    logic [VAL_W-1:0]  q11, q12, q21, q22;

    always_comb begin
        n_ix = lx_tag.xneg ? '0 : (lx_tag.xclp ? QB'(GRID_POINTS - 2) : lx_quo);
        n_iy = ly_tag.yneg ? '0 : (ly_tag.yclp ? QB'(GRID_POINTS - 2) : ly_quo);
        n_fx = lx_tag.xneg ? '0 : (lx_tag.xclp ? r_cell_x : lx_rem);
        n_fy = ly_tag.yneg ? '0 : (ly_tag.yclp ? r_cell_y : ly_rem);
        n_base = AW'(AW'(n_iy) * AW'(GRID_POINTS) + AW'(n_ix));
        n_a12  = AW'(n_base + AW'(1));
        n_a21  = AW'(n_base + AW'(GRID_POINTS));
        n_a22  = AW'(n_base + AW'(GRID_POINTS + 1));
        n_waddr = AW'(lx_tag.idx);
        n_we = adv && lx_vld && (lx_tag.ctl.mode == MODE_WRITE)
            && (32'(lx_tag.idx) < 32'(GS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gvld <= '0;
        end else if (n_we) begin
            r_gvld[n_waddr] <= 1'b1;
        end
    end

    bmz_ram #(.WIDTH(VAL_W), .DEPTH(GS)) u_ram_lo (
        .i_clk     (i_clk),
        .i_we      (n_we),
        .i_waddr   (n_waddr),
        .i_wdata   (lx_tag.val),
        .i_re      (adv),
        .i_raddr_a (n_base),
        .i_raddr_b (n_a12),
        .o_rdata_a (q11),
        .o_rdata_b (q12)
    );

    bmz_ram #(.WIDTH(VAL_W), .DEPTH(GS)) u_ram_hi (
        .i_clk     (i_clk),
        .i_we      (n_we),
        .i_waddr   (n_waddr),
        .i_wdata   (lx_tag.val),
        .i_re      (adv),
        .i_raddr_a (n_a21),
        .i_raddr_b (n_a22),
        .o_rdata_a (q21),
        .o_rdata_b (q22)
    );

    logic              rr_vld;
    t_ctl              rr_ctl;
    logic [VAL_W-1:0]  rr_n;
    logic [CELL_W-1:0] rr_fx, rr_fy;
    logic              rr_v11, rr_v12, rr_v21, rr_v22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rr_vld <= 1'b0;
        end else if (adv) begin
            rr_vld <= lx_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rr_ctl <= lx_tag.ctl;
            rr_n   <= lx_tag.n;
            rr_fx  <= n_fx;
            rr_fy  <= n_fy;
            rr_v11 <= r_gvld[n_base];
            rr_v12 <= r_gvld[n_a12];
            rr_v21 <= r_gvld[n_a21];
            rr_v22 <= r_gvld[n_a22];
        end
    end

    // corner differences
    logic [VAL_W-1:0]   n_m11, n_m12, n_m21, n_m22;
    logic signed [32:0] n_d1, n_d2, n_ad1, n_ad2;

    always_comb begin
        n_m11 = rr_v11 ? q11 : '0;
        n_m12 = rr_v12 ? q12 : '0;
        n_m21 = rr_v21 ? q21 : '0;
        n_m22 = rr_v22 ? q22 : '0;
        n_d1  = $signed({n_m12[31], n_m12}) - $signed({n_m11[31], n_m11});
        n_d2  = $signed({n_m22[31], n_m22}) - $signed({n_m21[31], n_m21});
        n_ad1 = n_d1[32] ? -n_d1 : n_d1;
        n_ad2 = n_d2[32] ? -n_d2 : n_d2;
    end

    logic              rd_vld;
    t_ctl              rd_ctl;
    logic [VAL_W-1:0]  rd_n, rd_m11, rd_m21, rd_a1, rd_a2;
    logic              rd_s1, rd_s2;
    logic [CELL_W-1:0] rd_fx, rd_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_vld <= 1'b0;
        end else if (adv) begin
            rd_vld <= rr_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rd_ctl <= rr_ctl;
            rd_n   <= rr_n;
            rd_m11 <= n_m11;
            rd_m21 <= n_m21;
            rd_s1  <= n_d1[32];
            rd_s2  <= n_d2[32];
            rd_a1  <= n_ad1[31:0];
            rd_a2  <= n_ad2[31:0];
            rd_fx  <= rr_fx;
            rd_fy  <= rr_fy;
        end
    end

    // products by x fraction
    logic              rp_vld;
    logic [PROD_W-1:0] rp_p1, rp_p2;
    t_fx_tag           rp_tag;
    t_fxh_tag          rp_htag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp_vld <= 1'b0;
        end else if (adv) begin
            rp_vld <= rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rp_p1       <= PROD_W'(rd_a1) * PROD_W'(rd_fx);
            rp_p2       <= PROD_W'(rd_a2) * PROD_W'(rd_fx);
            rp_tag.ctl  <= rd_ctl;
            rp_tag.n    <= rd_n;
            rp_tag.m11  <= rd_m11;
            rp_tag.s1   <= rd_s1;
            rp_tag.fy   <= rd_fy;
            rp_htag.s2  <= rd_s2;
            rp_htag.m21 <= rd_m21;
        end
    end

    logic             dx_vld;
    logic [VAL_W-1:0] dx_q1, dx_q2;
    t_fx_tag          dx_tag;
    t_fxh_tag         dx_htag;

    bmz_div #(.DW(PROD_W), .VW(CELL_W), .QW(VAL_W), .TW($bits(t_fx_tag))) u_div_x1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (rp_vld),
        .i_dvd   (rp_p1),
        .i_dvs   (r_cell_x),
        .i_tag   (rp_tag),
        .o_valid (dx_vld),
        .o_quo   (dx_q1),
        .o_rem   (),
        .o_tag   (dx_tag)
    );

    bmz_div #(.DW(PROD_W), .VW(CELL_W), .QW(VAL_W), .TW($bits(t_fxh_tag))) u_div_x2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (rp_vld),
        .i_dvd   (rp_p2),
        .i_dvs   (r_cell_x),
        .i_tag   (rp_htag),
        .o_valid (),
        .o_quo   (dx_q2),
        .o_rem   (),
        .o_tag   (dx_htag)
    );

    // row interpolation
    logic signed [32:0] n_o1, n_o2, n_zx1, n_zx2;

    always_comb begin
        n_o1  = dx_tag.s1 ? -$signed({1'b0, dx_q1}) : $signed({1'b0, dx_q1});
        n_o2  = dx_htag.s2 ? -$signed({1'b0, dx_q2}) : $signed({1'b0, dx_q2});
        n_zx1 = $signed({dx_tag.m11[31], dx_tag.m11}) + n_o1;
        n_zx2 = $signed({dx_htag.m21[31], dx_htag.m21}) + n_o2;
    end

    logic              rz_vld;
    t_ctl              rz_ctl;
    logic [VAL_W-1:0]  rz_n, rz_zx1, rz_zx2;
    logic [CELL_W-1:0] rz_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rz_vld <= 1'b0;
        end else if (adv) begin
            rz_vld <= dx_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rz_ctl <= dx_tag.ctl;
            rz_n   <= dx_tag.n;
            rz_zx1 <= n_zx1[31:0];
            rz_zx2 <= n_zx2[31:0];
            rz_fy  <= dx_tag.fy;
        end
    end

    logic signed [32:0] n_e, n_ae;

    always_comb begin
        n_e  = $signed({rz_zx2[31], rz_zx2}) - $signed({rz_zx1[31], rz_zx1});
        n_ae = n_e[32] ? -n_e : n_e;
    end

    logic              re_vld;
    t_ctl              re_ctl;
    logic [VAL_W-1:0]  re_n, re_zx1, re_ae;
    logic              re_se;
    logic [CELL_W-1:0] re_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            re_vld <= 1'b0;
        end else if (adv) begin
            re_vld <= rz_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            re_ctl <= rz_ctl;
            re_n   <= rz_n;
            re_zx1 <= rz_zx1;
            re_se  <= n_e[32];
            re_ae  <= n_ae[31:0];
            re_fy  <= rz_fy;
        end
    end

    logic              rf_vld;
    logic [PROD_W-1:0] rf_p;
    t_fy_tag           rf_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf_vld <= 1'b0;
        end else if (adv) begin
            rf_vld <= re_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rf_p       <= PROD_W'(re_ae) * PROD_W'(re_fy);
            rf_tag.ctl <= re_ctl;
            rf_tag.n   <= re_n;
            rf_tag.zx1 <= re_zx1;
            rf_tag.se  <= re_se;
        end
    end

    logic             dy_vld;
    logic [VAL_W-1:0] dy_q;
    t_fy_tag          dy_tag;

    bmz_div #(.DW(PROD_W), .VW(CELL_W), .QW(VAL_W), .TW($bits(t_fy_tag))) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (rf_vld),
        .i_dvd   (rf_p),
        .i_dvs   (r_cell_y),
        .i_tag   (rf_tag),
        .o_valid (dy_vld),
        .o_quo   (dy_q),
        .o_rem   (),
        .o_tag   (dy_tag)
    );

    // column interpolation
    logic signed [32:0] n_oy, n_corr;

    always_comb begin
        n_oy   = dy_tag.se ? -$signed({1'b0, dy_q}) : $signed({1'b0, dy_q});
        n_corr = $signed({dy_tag.zx1[31], dy_tag.zx1}) + n_oy;
    end

    logic             rc_vld;
    t_ctl             rc_ctl;
    logic [VAL_W-1:0] rc_n, rc_corr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rc_vld <= 1'b0;
        end else if (adv) begin
            rc_vld <= dy_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rc_ctl  <= dy_tag.ctl;
            rc_n    <= dy_tag.n;
            rc_corr <= n_corr[31:0];
        end
    end

    // fade product
    logic signed [32:0] n_c33, n_ac;

    always_comb begin
        n_c33 = $signed({rc_corr[31], rc_corr});
        n_ac  = rc_corr[31] ? -n_c33 : n_c33;
    end

    logic               rg_vld;
    logic [FPROD_W-1:0] rg_prod;
    t_fd_tag            rg_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rg_vld <= 1'b0;
        end else if (adv) begin
            rg_vld <= rc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rg_prod     <= FPROD_W'(n_ac[31:0]) * FPROD_W'(rc_n);
            rg_tag.ctl  <= rc_ctl;
            rg_tag.corr <= rc_corr;
            rg_tag.sc   <= rc_corr[31];
        end
    end

    logic             df_vld;
    logic [VAL_W-1:0] df_q;
    t_fd_tag          df_tag;

    bmz_div #(.DW(FPROD_W), .VW(VAL_W), .QW(VAL_W), .TW($bits(t_fd_tag))) u_div_fade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (rg_vld),
        .i_dvd   (rg_prod),
        .i_dvs   (r_fden),
        .i_tag   (rg_tag),
        .o_valid (df_vld),
        .o_quo   (df_q),
        .o_rem   (),
        .o_tag   (df_tag)
    );

    // result select
    logic [VAL_W-1:0] n_res;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_corr;

    always_comb begin
        priority if (df_tag.ctl.mode == MODE_WRITE || df_tag.ctl.kill) begin
            n_res = '0;
        end else if (df_tag.ctl.fade) begin
            n_res = df_tag.sc ? VAL_W'(-df_q) : df_q;
        end else begin
            n_res = df_tag.corr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= df_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_corr <= n_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_correction = r_corr;

`ifndef ASSERT_OFF
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable({r0_vld, rr_vld, rd_vld, rp_vld, rz_vld, re_vld, rf_vld, rc_vld,
                          rg_vld, r_out_valid}))
        else $error("pipeline valids moved during stall");

    a_grid_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_we |=> r_gvld[$past(n_waddr)])
        else $error("grid write did not mark entry valid");
`endif

endmodule
